/* hw/rtl/tsls_pkg.sv */
// Shared constants of the terrain subsection level selector.
package tsls_pkg;

    // Default configuration of the pipeline
    localparam int MAX_SUBSECTIONS_DEF = 2;
    localparam int FRAC_BITS_DEF       = 8;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SUB_QUADS   = 3'd0;
    localparam logic [2:0] REG_SUB_PER_SIDE = 3'd1;
    localparam logic [2:0] REG_MAX_LEVEL   = 3'd2;
    localparam logic [2:0] REG_LEVEL_BIAS  = 3'd3;
    localparam logic [2:0] REG_FORCED      = 3'd4;
    localparam logic [2:0] REG_LEVEL_DIST  = 3'd5;
    localparam logic [2:0] REG_DIST_OFFSET = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_SUB_QUADS    = 8'd63;
    localparam logic [1:0]  RST_SUB_PER_SIDE = 2'd1;
    localparam logic [2:0]  RST_MAX_LEVEL    = 3'd6;
    localparam logic [2:0]  RST_LEVEL_BIAS   = 3'd0;
    localparam logic [3:0]  RST_FORCED       = 4'hF;
    localparam logic [19:0] RST_LEVEL_DIST   = 20'd45617;
    localparam logic [18:0] RST_DIST_OFFSET  = 19'h7D374;

    localparam int CFG_DW   = 20;
    localparam int LEVEL_W  = 3;
    localparam int BATCH_W  = 5;
    localparam int ROOT_STEPS = 32;

endpackage

/* hw/rtl/terrain_subsection_lod_select.sv */
// Top level of the terrain subsection level selector: issuer, distance pipeline, output stage.
// Each accepted camera transaction yields one result per subsection, n*n results with n the
// saturated subsections_per_side (0 to MAX_SUBSECTIONS squared), issued one per cycle into a
// 42-stage pipeline: subsection centre, abs difference, square, sum, a 32-stage
// one-bit-per-stage square root, offset add, a four-stage restoring quotient that keeps three
// bits plus saturation, and the output register. The issuer sets the rate: a camera with n of
// 0 issues nothing, else the next camera is taken in the cycle its predecessor's last subsection
// enters. A stall on the result side holds the whole pipeline.
module terrain_subsection_lod_select
    import tsls_pkg::*;
#(
    parameter int MAX_SUBSECTIONS = MAX_SUBSECTIONS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    // camera stream; tdata: cam_x [31:0], cam_y [63:32]
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,
    // result stream; tdata: sub_col, sub_row, level, batch_index, zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [((2*(MAX_SUBSECTIONS > 1 ? $clog2(MAX_SUBSECTIONS) : 1)+8+7)/8)*8-1:0]
                                 m_axis_tdata,
    output logic                 m_axis_tlast
);

    localparam int IDXW = (MAX_SUBSECTIONS > 1) ? $clog2(MAX_SUBSECTIONS) : 1;
    localparam int DW   = 2*IDXW + LEVEL_W + BATCH_W;
    localparam int TW   = ((DW + 7) / 8) * 8;
    localparam int NW   = $clog2(MAX_SUBSECTIONS + 1) + 1;
    // pipeline stage indexes
    localparam int S_SQ   = 3;
    localparam int S_ROOT = S_SQ + ROOT_STEPS;
    localparam int S_OFS  = S_ROOT + 1;
    localparam int S_SAT  = S_OFS + 1;
    localparam int NST    = S_SAT + 4;

    typedef struct packed {
        logic [IDXW-1:0] col;
        logic [IDXW-1:0] row;
        logic            last;
    } t_meta;

    // configuration registers
    logic [7:0]        r_sub_quads;
    logic [1:0]        r_sub_side;
    logic [2:0]        r_max_level;
    logic [2:0]        r_bias;
    logic signed [3:0] r_forced;
    logic [19:0]       r_ldist;
    logic signed [18:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_quads <= RST_SUB_QUADS;
            r_sub_side  <= RST_SUB_PER_SIDE;
            r_max_level <= RST_MAX_LEVEL;
            r_bias      <= RST_LEVEL_BIAS;
            r_forced    <= RST_FORCED;
            r_ldist     <= RST_LEVEL_DIST;
            r_offset    <= RST_DIST_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SUB_QUADS:    r_sub_quads <= i_cfg_data[7:0];
                REG_SUB_PER_SIDE: r_sub_side  <= i_cfg_data[1:0];
                REG_MAX_LEVEL:    r_max_level <= i_cfg_data[2:0];
                REG_LEVEL_BIAS:   r_bias      <= i_cfg_data[2:0];
                REG_FORCED:       r_forced    <= i_cfg_data[3:0];
                REG_LEVEL_DIST:   r_ldist     <= i_cfg_data[19:0];
                REG_DIST_OFFSET:  r_offset    <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    // saturated subsection count, clamp top and forced check
    logic [NW-1:0] w_n;
    logic [2:0]    w_top;
    logic          w_forced;
    assign w_n = ({{(NW-2){1'b0}}, r_sub_side} > NW'(MAX_SUBSECTIONS)) ?
                 NW'(MAX_SUBSECTIONS) : {{(NW-2){1'b0}}, r_sub_side};
    assign w_top = (r_bias <= r_max_level) ? (r_max_level - r_bias) : 3'd0;
    assign w_forced = (r_bias <= r_max_level) && !r_forced[3] && (r_forced[2:0] <= w_top);

    // global advance: the output register is free or being taken
    logic r_out_vld;
    logic w_adv;
    assign w_adv = !r_out_vld || m_axis_tready;

    // issuer: walk the subsections of the held camera
    logic              r_busy;
    logic [IDXW-1:0]   r_col, r_row;
    logic signed [31:0] r_cx, r_cy;
    logic              w_job_last;
    logic              w_accept;
    assign w_job_last = ({{(NW-IDXW){1'b0}}, r_row} == w_n - NW'(1)) &&
                        ({{(NW-IDXW){1'b0}}, r_col} == w_n - NW'(1));
    assign s_axis_tready = w_adv && (!r_busy || w_job_last);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            if (w_accept) begin
                r_busy <= (w_n != '0);
            end else if (r_busy && w_job_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_accept) begin
                r_cx  <= s_axis_tdata[31:0];
                r_cy  <= s_axis_tdata[63:32];
                r_col <= '0;
                r_row <= '0;
            end else if (r_busy) begin
                if ({{(NW-IDXW){1'b0}}, r_col} == w_n - NW'(1)) begin
                    r_col <= '0;
                    r_row <= r_row + IDXW'(1);
                end else begin
                    r_col <= r_col + IDXW'(1);
                end
            end
        end
    end

    // valid bits and subsection tags travel with the data
    logic  r_vld  [NST];
    t_meta r_meta [NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= r_busy;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_meta[0] <= '{col: r_col, row: r_row, last: w_job_last};
            for (int k = 1; k < NST; k++) r_meta[k] <= r_meta[k-1];
        end
    end

    // stage 0: latch camera and subsection centre
    logic signed [31:0] r0_cx, r0_cy;
    logic [IDXW+8+FRAC_BITS:0] r0_ctrx, r0_ctry;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_cx   <= r_cx;
            r0_cy   <= r_cy;
            r0_ctrx <= ((IDXW+9+FRAC_BITS)'(r_col) * (IDXW+9+FRAC_BITS)'(r_sub_quads)
                        << FRAC_BITS) + ((IDXW+9+FRAC_BITS)'(r_sub_quads) << (FRAC_BITS-1));
            r0_ctry <= ((IDXW+9+FRAC_BITS)'(r_row) * (IDXW+9+FRAC_BITS)'(r_sub_quads)
                        << FRAC_BITS) + ((IDXW+9+FRAC_BITS)'(r_sub_quads) << (FRAC_BITS-1));
        end
    end

    // stage 1: absolute differences
    localparam int AW = (IDXW+10+FRAC_BITS > 33) ? IDXW+10+FRAC_BITS : 33;
    logic signed [AW:0] w_ddx, w_ddy;
    logic [32:0] r1_dx, r1_dy;
    assign w_ddx = (AW+1)'(r0_cx) - $signed({1'b0, (AW)'(r0_ctrx)});
    assign w_ddy = (AW+1)'(r0_cy) - $signed({1'b0, (AW)'(r0_ctry)});
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_dx <= 33'(w_ddx[AW] ? -w_ddx : w_ddx);
            r1_dy <= 33'(w_ddy[AW] ? -w_ddy : w_ddy);
        end
    end

    // stage 2: squares; stage 3: 64-bit sum
    logic [63:0] r2_sqx, r2_sqy;
    logic [63:0] r_rx [ROOT_STEPS+1];
    logic [63:0] r_rr [ROOT_STEPS+1];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sqx  <= 64'(r1_dx * r1_dx);
            r2_sqy  <= 64'(r1_dy * r1_dy);
            r_rx[0] <= r2_sqx + r2_sqy;
            r_rr[0] <= '0;
        end
    end

    // square root, one result bit per stage
    logic [63:0] n_rx [ROOT_STEPS];
    logic [63:0] n_rr [ROOT_STEPS];
    always_comb begin
        logic [63:0] b;
        logic [63:0] t;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            b = 64'd1 << (62 - 2*k);
            t = r_rr[k] + b;
            if (r_rx[k] >= t) begin
                n_rx[k] = r_rx[k] - t;
                n_rr[k] = (r_rr[k] >> 1) + b;
            end else begin
                n_rx[k] = r_rx[k];
                n_rr[k] = r_rr[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < ROOT_STEPS; k++) begin
                r_rx[k+1] <= n_rx[k];
                r_rr[k+1] <= n_rr[k];
            end
        end
    end

    // offset add
    logic signed [34:0] w_sum;
    logic        r_pos;
    logic [32:0] r_rem;
    assign w_sum = $signed({1'b0, r_rr[ROOT_STEPS][33:0]}) + 35'(r_offset);
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos <= !w_sum[34] && (w_sum != '0);
            r_rem <= w_sum[32:0];
        end
    end

    // quotient: saturation test, then three restoring steps
    logic        r_sat  [4];
    logic        r_pz   [4];
    logic [32:0] r_qrem [4];
    logic [2:0]  r_q    [4];
    always_ff @(posedge i_clk) begin
        logic [32:0] d;
        if (w_adv) begin
            r_sat[0]  <= r_rem >= (33'(r_ldist) << 3);
            r_pz[0]   <= r_pos;
            r_qrem[0] <= r_rem;
            r_q[0]    <= '0;
            for (int k = 1; k < 4; k++) begin
                d = 33'(r_ldist) << (3 - k);
                r_sat[k] <= r_sat[k-1];
                r_pz[k]  <= r_pz[k-1];
                if (r_qrem[k-1] >= d) begin
                    r_qrem[k] <= r_qrem[k-1] - d;
                    r_q[k]    <= r_q[k-1] | (3'd1 << (3 - k));
                end else begin
                    r_qrem[k] <= r_qrem[k-1];
                    r_q[k]    <= r_q[k-1];
                end
            end
        end
    end

    // level select and output register
    logic [2:0] w_lvl;
    logic [2:0] r_out_lvl;
    t_meta      r_out_meta;
    logic [BATCH_W-1:0] w_batch;
    always_comb begin
        if (w_forced) begin
            w_lvl = r_forced[2:0];
        end else if (!r_pz[3]) begin
            w_lvl = 3'd0;
        end else if (r_sat[3] || (r_q[3] > w_top)) begin
            w_lvl = w_top;
        end else begin
            w_lvl = r_q[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_lvl  <= w_lvl;
            r_out_meta <= r_meta[NST-1];
        end
    end

    assign w_batch = BATCH_W'(32'(r_out_lvl) * 32'(w_n) * 32'(w_n)
                     + 32'(r_out_meta.row) * 32'(w_n) + 32'(r_out_meta.col));
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_meta.last;
    assign m_axis_tdata  = TW'({w_batch, r_out_lvl, r_out_meta.row, r_out_meta.col});

    // the last subsection issued sits on the diagonal
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && r_meta[0].last |-> r_meta[0].col == r_meta[0].row)
        else $error("last tag off the diagonal");
    // a camera is taken only while the pipeline moves
    a_take_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> w_adv)
        else $error("camera taken during stall");
    // a forced level reaches the output unchanged
    a_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && w_forced |-> r_out_lvl == r_forced[2:0])
        else $error("forced level lost");
    // an empty component never starts a walk
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_n == '0 |=> !r_busy)
        else $error("walk started with no subsections");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the terrain subsection level selector.
`timescale 1ns / 100ps

module testbench;
    import tsls_pkg::*;

    localparam int OUT_W = 16;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic       col;
        logic       row;
        logic [2:0] level;
        logic [4:0] batch;
        logic       last;
    } t_lod_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [2:0]           i_cfg_index;
    logic [CFG_DW-1:0]    i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;   // cam_x [31:0], cam_y [63:32]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // sub_col, sub_row, level[2:0], batch_index[4:0]
    logic                 m_axis_tlast;

    // shadow copy of the block's registers
    logic [7:0]         sh_quads;
    logic [1:0]         sh_per_side;
    logic [2:0]         sh_max_level;
    logic [2:0]         sh_bias;
    logic signed [3:0]  sh_forced;
    logic [19:0]        sh_level_dist;
    logic signed [18:0] sh_offset;

    t_lod_result expected_lods[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    logic hold_off;

    terrain_subsection_lod_select DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Generate clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Integer square root with truncation
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Compute the levels of every subsection for one camera and queue them
    task automatic predict_lods(logic [31:0] cam_x, logic [31:0] cam_y);
        longint cx, cy, half, ctr_x, ctr_y, root_sum;
        longint unsigned dx, dy, dist_sq, quot;
        int n, top, lvl;
        bit forced;
        t_lod_result r;
        cx = longint'(signed'(cam_x));
        cy = longint'(signed'(cam_y));
        n = (sh_per_side > 2) ? 2 : int'(sh_per_side);
        top = (sh_bias <= sh_max_level) ? int'(sh_max_level) - int'(sh_bias) : 0;
        forced = (sh_bias <= sh_max_level) && (sh_forced >= 0) && (int'(sh_forced) <= top);
        for (int row = 0; row < n; row++) begin
            for (int col = 0; col < n; col++) begin
                if (forced) begin
                    lvl = int'(sh_forced);
                end else begin
                    half = longint'(sh_quads) << 7;
                    ctr_x = ((longint'(col) * longint'(sh_quads)) << 8) + half;
                    ctr_y = ((longint'(row) * longint'(sh_quads)) << 8) + half;
                    dx = (cx >= ctr_x) ? longint'(cx - ctr_x) : longint'(ctr_x - cx);
                    dy = (cy >= ctr_y) ? longint'(cy - ctr_y) : longint'(ctr_y - cy);
                    dist_sq = dx * dx + dy * dy;
                    root_sum = longint'(int_sqrt(dist_sq)) + longint'(sh_offset);
                    if (root_sum <= 0) begin
                        lvl = 0;
                    end else if (sh_level_dist == 0) begin
                        lvl = top;
                    end else begin
                        quot = longint'(root_sum) / longint'(sh_level_dist);
                        lvl = (quot > top) ? top : int'(quot);
                    end
                end
                r.col   = col[0];
                r.row   = row[0];
                r.level = lvl[2:0];
                r.batch = 5'(lvl * n * n + row * n + col);
                r.last  = (row == n - 1) && (col == n - 1);
                expected_lods.push_back(r);
            end
        end
    endtask

    // Write one register, mirror it, then leave the write port idle
    task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_SUB_QUADS:    sh_quads      = value[7:0];
            REG_SUB_PER_SIDE: sh_per_side   = value[1:0];
            REG_MAX_LEVEL:    sh_max_level  = value[2:0];
            REG_LEVEL_BIAS:   sh_bias       = value[2:0];
            REG_FORCED:       sh_forced     = value[3:0];
            REG_LEVEL_DIST:   sh_level_dist = value[19:0];
            REG_DIST_OFFSET:  sh_offset     = value[18:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(int quads, int per_side, int max_lvl, int bias, int forced_lvl,
                             int level_dist, int offset);
        write_reg(REG_SUB_QUADS, CFG_DW'(quads));
        write_reg(REG_SUB_PER_SIDE, CFG_DW'(per_side));
        write_reg(REG_MAX_LEVEL, CFG_DW'(max_lvl));
        write_reg(REG_LEVEL_BIAS, CFG_DW'(bias));
        write_reg(REG_FORCED, CFG_DW'(forced_lvl) & 20'hF);
        write_reg(REG_LEVEL_DIST, CFG_DW'(level_dist));
        write_reg(REG_DIST_OFFSET, CFG_DW'(offset) & 20'h7FFFF);
    endtask

    // Offer one camera transaction and predict on acceptance
    task automatic send_camera(logic [31:0] cam_x, logic [31:0] cam_y);
        if (!hold_off && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cam_y, cam_x};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_lods(cam_x, cam_y);
    endtask

    // Lower valid, let all results arrive, then let the pipeline settle
    task automatic drain;
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (expected_lods.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 600000)) - 200000);
    endfunction

    task automatic test_reset_values;
        send_camera(32'd0, 32'd0);
        send_camera(32'd8064, 32'd8064);           // exactly on the centre
        send_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_camera(32'h8000_0000, 32'h8000_0000);
        send_camera(32'h8000_0000, 32'h7FFF_FFFF);
        send_camera(32'd100000, 32'hFFFF_0000);
        drain();
    endtask

    task automatic test_special_cases;
        // two by two subsections, small step
        configure(255, 2, 7, 0, -1, 20000, 0);
        send_camera(32'd0, 32'd0);
        send_camera(32'd300000, 32'd50000);
        send_camera(32'hFFFF_FFFF, 32'h0000_FFFF);
        drain();
        // too many subsections saturate
        configure(1, 3, 7, 0, -1, 1, -262144);
        send_camera(32'd1000000, 32'd1000000);
        send_camera(32'd128, 32'd128);
        drain();
        // forced level inside range
        configure(63, 2, 5, 2, 3, 45617, -11404);
        send_camera(32'd555555, 32'd0);
        drain();
        // forced level above range, and bias above maximum
        write_reg(REG_FORCED, 20'd7);
        send_camera(32'd900000, 32'd12345);
        drain();
        write_reg(REG_LEVEL_BIAS, 20'd6);
        send_camera(32'd900000, 32'd12345);
        drain();
        // zero level distance
        configure(100, 2, 7, 1, -1, 0, -1000);
        send_camera(32'd12800, 32'd12800);
        send_camera(32'd200000, 32'd12800);
        drain();
        // no subsections: nothing comes out
        configure(200, 0, 4, 0, 2, 1048575, 0);
        send_camera(32'd5, 32'd5);
        send_camera(32'h8000_0000, 32'd5);
        drain();
        configure(255, 1, 0, 0, 0, 1048575, 0);
        send_camera(32'h7FFF_FFFF, 32'd0);
        drain();
    endtask

    task automatic random_config;
        int n_sel;
        n_sel = $urandom_range(9);
        configure($urandom_range(1, 255), (n_sel == 0) ? 0 : (n_sel == 1) ? 3
                  : $urandom_range(1, 2), $urandom_range(7), $urandom_range(3),
                  ($urandom_range(3) == 0) ? $urandom_range(15) : 15,
                  ($urandom_range(7) == 0) ? $urandom_range(0, 1048575)
                  : $urandom_range(2000, 60000),
                  -$urandom_range(0, 262144));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < items; k++) begin
            if (k % 22 == 0) begin
                drain();
                random_config();
            end
            if ($urandom_range(4) == 0)
                send_camera($urandom, $urandom);
            else
                send_camera(near_coord(), near_coord());
        end
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(255, 2, 7, 0, -1, 30000, -5000);
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int k = 0; k < 40; k++) send_camera(near_coord(), near_coord());
        drain();
    endtask

    // Drive the result side ready
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_lod_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_lods.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                e = expected_lods.pop_front();
                if (m_axis_tdata[0] !== e.col) begin
                    $error("sub_col expected %0d got %0d", e.col, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[1] !== e.row) begin
                    $error("sub_row expected %0d got %0d", e.row, m_axis_tdata[1]);
                    errors++;
                end
                if (m_axis_tdata[4:2] !== e.level) begin
                    $error("level expected %0d got %0d", e.level, m_axis_tdata[4:2]);
                    errors++;
                end
                if (m_axis_tdata[9:5] !== e.batch) begin
                    $error("batch_index expected %0d got %0d", e.batch, m_axis_tdata[9:5]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last expected %0d got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Run the tests in turn
    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_SUB_QUADS;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        sh_quads       = RST_SUB_QUADS;
        sh_per_side    = RST_SUB_PER_SIDE;
        sh_max_level   = RST_MAX_LEVEL;
        sh_bias        = RST_LEVEL_BIAS;
        sh_forced      = RST_FORCED;
        sh_level_dist  = RST_LEVEL_DIST;
        sh_offset      = RST_DIST_OFFSET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_special_cases();
        test_random_phase(0, 0, 72);
        test_random_phase(83, 0, 72);
        test_random_phase(0, 83, 72);
        test_random_phase(12, 12, 72);
        test_backpressure();
        // results still owed count as a failure
        if (errors == 0 && expected_lods.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
